>>> src/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types and constants of the canonical Huffman table decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package chd_pkg;

  localparam int LUT_BITS_DEF    = 12;
  localparam int MAX_SYMBOLS_DEF = 512;
  localparam int CODE_LEN_MAX    = 16;

  localparam logic [9:0] NUM_SYMBOLS_RESET = 10'd510;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_BUILD  = 2'd1,
    KIND_FILL   = 2'd2,
    KIND_DECODE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_TOO_LONG  = 2'd1,
    ERR_BAD_TOTAL = 2'd2,
    ERR_BAD_ENTRY = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    WH_TABLE = 2'd0,
    WH_LEFT  = 2'd1,
    WH_RIGHT = 2'd2
  } where_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_EV,
    ST_TOTAL,
    ST_CLEAR,
    ST_AS_RD,
    ST_AS_EV,
    ST_RUN,
    ST_LK_RD,
    ST_LK_EV,
    ST_NEW_SLOT,
    ST_LEAF,
    ST_FILL,
    ST_DEC_TBL,
    ST_DEC_LNK,
    ST_DEC_LEN
  } state_e;

  typedef struct packed {
    kind_e       kind;
    logic [8:0]  symbol_index;
    logic [4:0]  code_length;
    logic [8:0]  fill_symbol;
    logic [15:0] bit_window;
  } req_t;

  typedef struct packed {
    logic [8:0] symbol;
    logic [4:0] bits_used;
    err_e       error;
  } res_t;

endpackage

`default_nettype wire

>>> src/canonical_huffman_table_decoder_core.sv
// Load: written from idle. Decode: a table hit then reads the code length; a
// tree decode reads one link per tree step (at most 16 - LUT_BITS steps).
// Build: counts the lengths, sums the code space, clears the table, then writes
// table entries and tree links through the single table and link RAM ports.
// Fill: sweeps max(2^LUT_BITS, MAX_SYMBOLS) entries. Results cannot be stalled.
// Reset sets num_symbols to 510 and the node counter to zero; RAMs are not cleared.
// ----------------------------------------------------------------------------
// canonical_huffman_table_decoder_core
// Canonical Huffman table builder and decoder with a direct lookup table and a
// binary tree for long codes, run by one sequencer over shared RAM ports.
// ----------------------------------------------------------------------------
`default_nettype none

module canonical_huffman_table_decoder_core
  import chd_pkg::*;
#(
  parameter int LUT_BITS    = LUT_BITS_DEF,
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [9:0] cfg_wdata_i,
  input  wire logic       start,
  input  wire req_t       req_i,
  output logic            busy,
  output logic            result_valid_o,
  output res_t            result_o
);

  localparam int TableSize = 1 << LUT_BITS;
  localparam int NodeCap   = 2 * MAX_SYMBOLS - 1;
  localparam int NW        = $clog2(NodeCap);
  localparam int LW        = $clog2(MAX_SYMBOLS);
  localparam int TW        = (NW > 9) ? NW : 9;
  localparam int NSW       = $clog2(MAX_SYMBOLS + 1);
  localparam int Sweep     = (TableSize > MAX_SYMBOLS) ? TableSize : MAX_SYMBOLS;
  localparam int CW        = $clog2(Sweep + 1);
  localparam int IW        = (LUT_BITS > NW) ? LUT_BITS : NW;
  localparam int M         = CODE_LEN_MAX - LUT_BITS;
  localparam int BitTop    = (LUT_BITS < CODE_LEN_MAX) ? (15 - LUT_BITS) : 0;
  localparam int XW        = 18;

  state_e state_q, state_d;
  logic [9:0] cfg_q;
  logic res_valid_q, res_valid_d;
  res_t res_q, res_d;
  logic [NW-1:0] avail_q, avail_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] sym_q, sym_d;
  logic [LUT_BITS:0] run_end_q, run_end_d;
  logic [15:0] first_q, first_d;
  logic [IW-1:0] idx_q, idx_d;
  where_e where_q, where_d;
  logic [3:0] k_q, k_d;
  logic [4:0] clen_q, clen_d;
  logic [4:0] lc_q, lc_d;
  logic [26:0] total_q, total_d;
  logic [15:0] win_q, win_d;
  logic [TW-1:0] v_q, v_d;
  logic [4:0] bits_q, bits_d;
  logic dir_q, dir_d;
  logic [8:0] fill_q, fill_d;
  logic [NSW-1:0] count_q [0:16];
  logic [NSW-1:0] count_d [0:16];
  logic [16:0] start_q [0:16];
  logic [16:0] start_d [0:16];

  logic len_we;
  logic [LW-1:0] len_wa, len_ra;
  logic [4:0] len_wd, len_rd;
  logic tbl_we;
  logic [LUT_BITS-1:0] tbl_wa, tbl_ra;
  logic [TW-1:0] tbl_wd, tbl_rd;
  logic lft_we, rgt_we;
  logic [NW-1:0] lft_wa, rgt_wa, lnk_ra;
  logic [TW-1:0] lft_wd, rgt_wd, lft_rd, rgt_rd;

  logic [XW-1:0] n_x, cap_x;
  logic [15:0] first_sh, win_sh;
  logic step_dir;
  logic adv;
  logic [XW-1:0] last_x;
  logic [15:0] first16;
  logic [26:0] add_w, total_n;
  logic [TW-1:0] slot, cur_v;
  logic [4:0] cur_bits;
  logic [4:0] cur_len;
  logic slot_we;
  logic [TW-1:0] slot_wd;
  logic steps_done;

  chd_ram #(.DEPTH(MAX_SYMBOLS), .AW(LW), .DW(5)) u_len (
    .clk_i, .we_i(len_we), .waddr_i(len_wa), .wdata_i(len_wd),
    .raddr_i(len_ra), .rdata_o(len_rd)
  );
  chd_ram #(.DEPTH(TableSize), .AW(LUT_BITS), .DW(TW)) u_tbl (
    .clk_i, .we_i(tbl_we), .waddr_i(tbl_wa), .wdata_i(tbl_wd),
    .raddr_i(tbl_ra), .rdata_o(tbl_rd)
  );
  chd_ram #(.DEPTH(NodeCap), .AW(NW), .DW(TW)) u_left (
    .clk_i, .we_i(lft_we), .waddr_i(lft_wa), .wdata_i(lft_wd),
    .raddr_i(lnk_ra), .rdata_o(lft_rd)
  );
  chd_ram #(.DEPTH(NodeCap), .AW(NW), .DW(TW)) u_right (
    .clk_i, .we_i(rgt_we), .waddr_i(rgt_wa), .wdata_i(rgt_wd),
    .raddr_i(lnk_ra), .rdata_o(rgt_rd)
  );

  // Effective alphabet size: zero acts as one, large values saturate.
  always_comb begin
    if (cfg_q == 10'd0) begin
      n_x = XW'(1);
    end else if (XW'(cfg_q) > XW'(MAX_SYMBOLS)) begin
      n_x = XW'(MAX_SYMBOLS);
    end else begin
      n_x = XW'(cfg_q);
    end
    cap_x = (n_x << 1) - XW'(1);
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  always_comb begin
    state_d     = state_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    avail_d     = avail_q;
    cnt_d       = cnt_q;
    sym_d       = sym_q;
    run_end_d   = run_end_q;
    first_d     = first_q;
    idx_d       = idx_q;
    where_d     = where_q;
    k_d         = k_q;
    clen_d      = clen_q;
    lc_d        = lc_q;
    total_d     = total_q;
    win_d       = win_q;
    v_d         = v_q;
    bits_d      = bits_q;
    dir_d       = dir_q;
    fill_d      = fill_q;
    count_d     = count_q;
    start_d     = start_q;

    len_we = 1'b0;
    len_wa = LW'(cnt_q);
    len_wd = 5'd0;
    len_ra = LW'(cnt_q);
    tbl_we = 1'b0;
    tbl_wa = cnt_q[LUT_BITS-1:0];
    tbl_wd = '0;
    tbl_ra = idx_q[LUT_BITS-1:0];
    lft_we = 1'b0;
    lft_wa = avail_q;
    lft_wd = '0;
    rgt_we = 1'b0;
    rgt_wa = avail_q;
    rgt_wd = '0;
    lnk_ra = idx_q[NW-1:0];

    adv      = 1'b0;
    slot_we  = 1'b0;
    slot_wd  = '0;
    last_x   = '0;
    first16  = start_q[clen_q][15:0];
    add_w    = 27'(count_q[lc_q]) << (5'd16 - lc_q);
    total_n  = total_q + add_w;
    first_sh = first_q << k_q;
    step_dir = first_sh[BitTop];
    win_sh   = '0;
    cur_len  = len_rd;
    steps_done = (XW'(k_q) + XW'(1)) == (XW'(clen_q) - XW'(LUT_BITS));

    unique case (where_q)
      WH_LEFT:  slot = lft_rd;
      WH_RIGHT: slot = rgt_rd;
      default:  slot = tbl_rd;
    endcase

    if (state_q == ST_DEC_TBL) begin
      cur_v    = tbl_rd;
      cur_bits = 5'(LUT_BITS);
    end else begin
      cur_v    = dir_q ? rgt_rd : lft_rd;
      cur_bits = bits_q;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (req_i.kind)
            KIND_LOAD: begin
              if (XW'(req_i.symbol_index) < XW'(MAX_SYMBOLS)) begin
                len_we = 1'b1;
                len_wa = LW'(req_i.symbol_index);
                len_wd = req_i.code_length;
              end
            end
            KIND_BUILD: begin
              for (int i = 0; i <= 16; i++) begin
                count_d[i] = '0;
              end
              cnt_d   = '0;
              state_d = ST_CNT_RD;
            end
            KIND_FILL: begin
              fill_d  = req_i.fill_symbol;
              cnt_d   = '0;
              state_d = ST_FILL;
            end
            KIND_DECODE: begin
              win_d   = req_i.bit_window;
              tbl_ra  = req_i.bit_window[15 -: LUT_BITS];
              state_d = ST_DEC_TBL;
            end
            default: ;
          endcase
        end
      end

      ST_CNT_RD: begin
        state_d = ST_CNT_EV;
      end

      ST_CNT_EV: begin
        if (len_rd > 5'd16) begin
          res_valid_d = 1'b1;
          res_d       = '{symbol: '0, bits_used: '0, error: ERR_TOO_LONG};
          state_d     = ST_IDLE;
        end else begin
          count_d[len_rd] = count_q[len_rd] + NSW'(1);
          if (XW'(cnt_q) + XW'(1) == n_x) begin
            lc_d    = 5'd1;
            total_d = '0;
            state_d = ST_TOTAL;
          end else begin
            cnt_d   = cnt_q + CW'(1);
            state_d = ST_CNT_RD;
          end
        end
      end

      ST_TOTAL: begin
        // Short code starts are kept in table-index units.
        if (XW'(lc_q) <= XW'(LUT_BITS)) begin
          start_d[lc_q] = 17'(total_q[15:0] >> M);
        end else begin
          start_d[lc_q] = 17'(total_q[15:0]);
        end
        total_d = total_n;
        if (lc_q == 5'd16) begin
          if (total_n[15:0] != 16'd0) begin
            res_valid_d = 1'b1;
            res_d       = '{symbol: '0, bits_used: '0, error: ERR_BAD_TOTAL};
            state_d     = ST_IDLE;
          end else begin
            cnt_d   = '0;
            avail_d = NW'(n_x);
            state_d = ST_CLEAR;
          end
        end else begin
          lc_d = lc_q + 5'd1;
        end
      end

      ST_CLEAR: begin
        tbl_we = 1'b1;
        tbl_wd = '0;
        if (XW'(cnt_q) == XW'(TableSize - 1)) begin
          sym_d   = '0;
          state_d = ST_AS_RD;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end

      ST_AS_RD: begin
        len_ra  = sym_q;
        state_d = ST_AS_EV;
      end

      ST_AS_EV: begin
        clen_d  = cur_len;
        first16 = start_q[cur_len][15:0];
        if (cur_len == 5'd0) begin
          adv = 1'b1;
        end else if (XW'(cur_len) <= XW'(LUT_BITS)) begin
          last_x = XW'(start_q[cur_len]) + (XW'(1) << (XW'(LUT_BITS) - XW'(cur_len)));
          if (last_x > XW'(TableSize)) begin
            res_valid_d = 1'b1;
            res_d       = '{symbol: '0, bits_used: '0, error: ERR_BAD_ENTRY};
            state_d     = ST_IDLE;
          end else begin
            start_d[cur_len] = last_x[16:0];
            cnt_d            = CW'(start_q[cur_len]);
            run_end_d        = last_x[LUT_BITS:0];
            state_d          = ST_RUN;
          end
        end else begin
          first_d = first16;
          idx_d   = IW'(first16 >> M);
          start_d[cur_len] = 17'(({1'b0, first16} + (17'(1) << (5'd16 - cur_len)))
                                 & 17'h0ffff);
          where_d = WH_TABLE;
          k_d     = '0;
          state_d = ST_LK_RD;
        end
      end

      ST_RUN: begin
        tbl_we = 1'b1;
        tbl_wd = TW'(sym_q);
        if (XW'(cnt_q) + XW'(1) == XW'(run_end_q)) begin
          adv = 1'b1;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end

      ST_LK_RD: begin
        state_d = ST_LK_EV;
      end

      ST_LK_EV: begin
        // A slot holding a symbol counts as empty and gets a fresh node.
        if (XW'(slot) < n_x) begin
          if (XW'(avail_q) >= cap_x) begin
            res_valid_d = 1'b1;
            res_d       = '{symbol: '0, bits_used: '0, error: ERR_BAD_ENTRY};
            state_d     = ST_IDLE;
          end else begin
            lft_we  = 1'b1;
            rgt_we  = 1'b1;
            state_d = ST_NEW_SLOT;
          end
        end else begin
          idx_d   = IW'(slot);
          where_d = step_dir ? WH_RIGHT : WH_LEFT;
          k_d     = k_q + 4'd1;
          state_d = steps_done ? ST_LEAF : ST_LK_RD;
        end
      end

      ST_NEW_SLOT: begin
        slot_we = 1'b1;
        slot_wd = TW'(avail_q);
        idx_d   = IW'(avail_q);
        avail_d = avail_q + NW'(1);
        where_d = step_dir ? WH_RIGHT : WH_LEFT;
        k_d     = k_q + 4'd1;
        state_d = steps_done ? ST_LEAF : ST_LK_RD;
      end

      ST_LEAF: begin
        slot_we = 1'b1;
        slot_wd = TW'(sym_q);
        adv     = 1'b1;
      end

      ST_FILL: begin
        tbl_we = (XW'(cnt_q) < XW'(TableSize));
        tbl_wd = TW'(fill_q);
        len_we = (XW'(cnt_q) < n_x);
        len_wd = 5'd0;
        if (XW'(cnt_q) + XW'(1) == XW'(Sweep)) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end

      ST_DEC_TBL, ST_DEC_LNK: begin
        if (XW'(cur_v) < n_x) begin
          if (state_q == ST_DEC_TBL) begin
            len_ra  = LW'(cur_v);
            v_d     = cur_v;
            state_d = ST_DEC_LEN;
          end else begin
            res_valid_d = 1'b1;
            res_d       = '{symbol: cur_v[8:0], bits_used: cur_bits, error: ERR_OK};
            state_d     = ST_IDLE;
          end
        end else if (cur_bits >= 5'd16 || XW'(cur_v) >= XW'(NodeCap)) begin
          res_valid_d = 1'b1;
          res_d       = '{symbol: '0, bits_used: 5'd16, error: ERR_BAD_ENTRY};
          state_d     = ST_IDLE;
        end else begin
          win_sh  = win_q << cur_bits;
          lnk_ra  = cur_v[NW-1:0];
          dir_d   = win_sh[15];
          bits_d  = cur_bits + 5'd1;
          state_d = ST_DEC_LNK;
        end
      end

      ST_DEC_LEN: begin
        res_valid_d = 1'b1;
        res_d       = '{symbol: v_q[8:0],
                        bits_used: (len_rd > 5'd16) ? 5'd16 : len_rd,
                        error: ERR_OK};
        state_d     = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase

    // The tree slot being linked lives in the table or in one link RAM.
    if (slot_we) begin
      unique case (where_q)
        WH_LEFT: begin
          lft_we = 1'b1;
          lft_wa = idx_q[NW-1:0];
          lft_wd = slot_wd;
        end
        WH_RIGHT: begin
          rgt_we = 1'b1;
          rgt_wa = idx_q[NW-1:0];
          rgt_wd = slot_wd;
        end
        default: begin
          tbl_we = 1'b1;
          tbl_wa = idx_q[LUT_BITS-1:0];
          tbl_wd = slot_wd;
        end
      endcase
    end

    if (adv) begin
      if (XW'(sym_q) + XW'(1) == n_x) begin
        res_valid_d = 1'b1;
        res_d       = '{symbol: '0, bits_used: '0, error: ERR_OK};
        state_d     = ST_IDLE;
      end else begin
        sym_d   = sym_q + LW'(1);
        state_d = ST_AS_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      cfg_q       <= NUM_SYMBOLS_RESET;
      avail_q     <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      avail_q     <= avail_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    cnt_q     <= cnt_d;
    sym_q     <= sym_d;
    run_end_q <= run_end_d;
    first_q   <= first_d;
    idx_q     <= idx_d;
    where_q   <= where_d;
    k_q       <= k_d;
    clen_q    <= clen_d;
    lc_q      <= lc_d;
    total_q   <= total_d;
    win_q     <= win_d;
    v_q       <= v_d;
    bits_q    <= bits_d;
    dir_q     <= dir_d;
    fill_q    <= fill_d;
    count_q   <= count_d;
    start_q   <= start_d;
  end

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.kind == KIND_LOAD) |=> (!result_valid_o && !busy))
    else $error("load item produced a result or kept the block busy");

  a_node_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NEW_SLOT) |-> (XW'(avail_q) < cap_x))
    else $error("tree node allocated beyond the node pool");

  a_run_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (XW'(cnt_q) < XW'(TableSize)))
    else $error("table run writes past the end of the table");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result delivered while the sequencer is still busy");

endmodule

`default_nettype wire

>>> src/chd_ram.sv
// ----------------------------------------------------------------------------
// chd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_ram #(
  parameter int DEPTH = 512,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> bench/tb_canonical_huffman_table_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_canonical_huffman_table_decoder_core
// Self-checking bench for the canonical Huffman table decoder. A directed table
// covers length errors, fills and oversubscribed codes; random phases then load
// canonical code sets (some deliberately broken), build, and decode.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_canonical_huffman_table_decoder_core;
  import chd_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [9:0] cfg_wdata_i = '0;
  logic       start = 1'b0;
  req_t       req_i = '0;
  logic       busy;
  logic       result_valid_o;
  res_t       result_o;

  canonical_huffman_table_decoder_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .start(start), .req_i(req_i), .busy(busy),
    .result_valid_o(result_valid_o), .result_o(result_o)
  );

  always #10 clk_i = ~clk_i;

  // Mirror of the decoder state, with flags for storage written since reset.
  logic [9:0] alpha_reg;
  logic [4:0] len_mem [512];
  logic [9:0] tbl_mem [4096];
  logic [9:0] left_mem [1023];
  logic [9:0] right_mem [1023];
  bit         tbl_valid;
  bit         node_valid [1023];

  res_t exp_q[$];
  int   fail_cnt = 0;
  int   burst_left = 0;
  int   item_cnt = 0;

  int   tgt_len [512];
  bit   taken [512];
  int   leaf [128];

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_cnt++;
  endtask

  function automatic int alphabet_size();
    if (alpha_reg == 0) return 1;
    if (alpha_reg > 512) return 512;
    return alpha_reg;
  endfunction

  function automatic int read_slot(where_e wh, int idx);
    if (wh == WH_TABLE) return tbl_mem[idx & 4095];
    if (wh == WH_LEFT) return left_mem[idx % 1023];
    return right_mem[idx % 1023];
  endfunction

  function automatic void write_slot(where_e wh, int idx, int val);
    if (wh == WH_TABLE) tbl_mem[idx & 4095] = 10'(val);
    else if (wh == WH_LEFT) left_mem[idx % 1023] = 10'(val);
    else right_mem[idx % 1023] = 10'(val);
  endfunction

  function automatic err_e build_table();
    int n, cap, total, avail, first, last, clen, idx, val;
    int cnt [17];
    int wt [17];
    int st [17];
    where_e wh;
    n = alphabet_size();
    cap = 2 * n - 1;
    for (int i = 0; i < 17; i++) cnt[i] = 0;
    for (int s = 0; s < n; s++) begin
      if (len_mem[s] > 16) return ERR_TOO_LONG;
      cnt[len_mem[s]]++;
    end
    total = 0;
    st[0] = 0;
    wt[0] = 0;
    for (int i = 1; i <= 16; i++) begin
      wt[i] = 1 << (16 - i);
      st[i] = total & 16'hffff;
      total += wt[i] * cnt[i];
    end
    if ((total & 16'hffff) != 0) return ERR_BAD_TOTAL;
    for (int i = 1; i <= 12; i++) begin
      st[i] = st[i] >> 4;
      wt[i] = wt[i] >> 4;
    end
    for (int i = 0; i < 4096; i++) tbl_mem[i] = '0;
    tbl_valid = 1'b1;
    avail = n;
    for (int s = 0; s < n; s++) begin
      clen = len_mem[s];
      if (clen == 0) continue;
      first = st[clen];
      if (clen <= 12) begin
        last = first + wt[clen];
        if (last > 4096) return ERR_BAD_ENTRY;
        st[clen] = last;
        for (int i = first; i < last; i++) tbl_mem[i] = 10'(s);
      end else begin
        wh = WH_TABLE;
        idx = first >> 4;
        st[clen] = (first + wt[clen]) & 16'hffff;
        for (int k = 0; k < clen - 12; k++) begin
          val = read_slot(wh, idx);
          // A slot still holding a symbol is treated as empty.
          if (val < n) begin
            if (avail >= cap) return ERR_BAD_ENTRY;
            left_mem[avail] = '0;
            right_mem[avail] = '0;
            node_valid[avail] = 1'b1;
            write_slot(wh, idx, avail);
            val = avail;
            avail++;
          end
          idx = val;
          wh = ((first >> (3 - k)) & 1) ? WH_RIGHT : WH_LEFT;
        end
        write_slot(wh, idx, s);
      end
    end
    return ERR_OK;
  endfunction

  // Predicts one decode; clears safe when it would touch unwritten storage.
  function automatic res_t decode_window(logic [15:0] win, output bit safe);
    res_t r;
    int n, v, bits;
    n = alphabet_size();
    safe = tbl_valid;
    r = '0;
    v = tbl_mem[win[15:4]];
    if (v < n) begin
      bits = len_mem[v % 512];
      if (bits > 16) bits = 16;
    end else begin
      bits = 12;
      while (v >= n) begin
        if (bits >= 16 || v >= 1023) begin
          r.bits_used = 5'd16;
          r.error = ERR_BAD_ENTRY;
          return r;
        end
        if (!node_valid[v]) safe = 1'b0;
        v = win[15 - bits] ? right_mem[v] : left_mem[v];
        bits++;
      end
    end
    r.symbol = v[8:0];
    r.bits_used = bits[4:0];
    r.error = ERR_OK;
    return r;
  endfunction

  task automatic apply_item(req_t r, bit typed, res_t want);
    res_t p;
    bit ok;
    int n;
    n = alphabet_size();
    p = '0;
    case (r.kind)
      KIND_LOAD: len_mem[r.symbol_index] = r.code_length;
      KIND_BUILD: begin
        p.error = build_table();
        exp_q.push_back(typed ? want : p);
      end
      KIND_FILL: begin
        for (int i = 0; i < n; i++) len_mem[i] = '0;
        for (int i = 0; i < 4096; i++) tbl_mem[i] = {1'b0, r.fill_symbol};
        tbl_valid = 1'b1;
      end
      default: begin
        p = decode_window(r.bit_window, ok);
        exp_q.push_back(typed ? want : p);
      end
    endcase
  endtask

  task automatic send_item(req_t r, bit typed = 1'b0, res_t want = '0);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    apply_item(r, typed, want);
    item_cnt++;
  endtask

  // Waits until the block has drained, then changes the alphabet size.
  task automatic set_alphabet(logic [9:0] val);
    start <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (5000) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    alpha_reg = val;
  endtask

  function automatic req_t mk(kind_e k, int a, int b, int c, int d);
    req_t r;
    r.kind = k;
    r.symbol_index = 9'(a);
    r.code_length = 5'(b);
    r.fill_symbol = 9'(c);
    r.bit_window = 16'(d);
    return r;
  endfunction

  // Places a complete prefix code of cnt leaves on unused symbols below n.
  task automatic place_code(int n, int cnt);
    int m, j, deep, s;
    leaf[0] = (cnt == 1) ? 0 : 1;
    leaf[1] = 1;
    m = (cnt == 1) ? 1 : 2;
    while (m < cnt) begin
      j = $urandom_range(0, m - 1);
      if ($urandom_range(0, 1) == 1) begin
        deep = -1;
        for (int i = 0; i < m; i++)
          if (leaf[i] < 16 && (deep < 0 || leaf[i] > leaf[deep])) deep = i;
        j = deep;
      end
      while (leaf[j] >= 16) j = $urandom_range(0, m - 1);
      leaf[j]++;
      leaf[m] = leaf[j];
      m++;
    end
    for (int i = 0; i < cnt; i++) begin
      do s = $urandom_range(0, n - 1); while (taken[s]);
      taken[s] = 1'b1;
      tgt_len[s] = leaf[i];
    end
  endtask

  task automatic random_round();
    int n, cnt, free_cnt, mode, s, ndec;
    logic [15:0] win;
    bit ok;
    res_t dummy;
    req_t r;
    n = alphabet_size();
    if ($urandom_range(0, 9) == 0) begin
      send_item(mk(KIND_FILL, $urandom, $urandom, $urandom, $urandom));
    end else begin
      for (int i = 0; i < 512; i++) begin
        tgt_len[i] = 0;
        taken[i] = 1'b0;
      end
      cnt = (n < 2) ? 1 : $urandom_range(2, (n < 48) ? n : 48);
      place_code(n, cnt);
      mode = $urandom_range(0, 7);
      free_cnt = n - cnt;
      if (mode == 0 && free_cnt >= 2)
        place_code(n, $urandom_range(2, (free_cnt < 40) ? free_cnt : 40));
      else if (mode == 1)
        tgt_len[$urandom_range(0, n - 1)] = $urandom_range(17, 31);
      else if (mode == 2) begin
        s = $urandom_range(0, n - 1);
        tgt_len[s] = (tgt_len[s] + 1) % 17;
      end
      for (int i = 0; i < n; i++)
        if (len_mem[i] != tgt_len[i]) send_item(mk(KIND_LOAD, i, tgt_len[i], $urandom,
                                                   $urandom));
      if (n < 512 && $urandom_range(0, 4) == 0)
        send_item(mk(KIND_LOAD, $urandom_range(n, 511), $urandom_range(0, 31), $urandom,
                     $urandom));
      send_item(mk(KIND_BUILD, $urandom, $urandom, $urandom, $urandom));
    end
    ndec = $urandom_range(5, 20);
    for (int i = 0; i < ndec; i++) begin
      win = 16'($urandom);
      // Long codes sit near the all-ones end of the code space.
      if ($urandom_range(0, 1) == 1) win[15:4] = 12'(12'hfff - $urandom_range(0, 3));
      dummy = decode_window(win, ok);
      if (ok) send_item(mk(KIND_DECODE, $urandom, $urandom, $urandom, win));
    end
  endtask

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && result_valid_o) begin
      if (exp_q.size() == 0) begin
        report_mismatch("unexpected result count", 1, 0);
      end else begin
        e = exp_q.pop_front();
        if (result_o.symbol != e.symbol)
          report_mismatch("symbol", result_o.symbol, e.symbol);
        if (result_o.bits_used != e.bits_used)
          report_mismatch("bits_used", result_o.bits_used, e.bits_used);
        if (result_o.error != e.error)
          report_mismatch("error", result_o.error, e.error);
      end
    end
  end

  typedef struct {
    req_t rq;
    bit   typed;
    res_t want;
  } row_t;

  row_t rows[$];

  task automatic add_row(kind_e k, int a, int b, int c, int d, bit typed = 1'b0,
                         int sym = 0, int bits = 0, err_e er = ERR_OK);
    row_t rw;
    rw.rq = mk(k, a, b, c, d);
    rw.typed = typed;
    rw.want.symbol = 9'(sym);
    rw.want.bits_used = 5'(bits);
    rw.want.error = er;
    rows.push_back(rw);
  endtask

  initial begin
    logic [9:0] alpha_list [9];
    int target;
    alpha_list = '{10'd1, 10'd1023, 10'd0, 10'd2, 10'd37, 10'd512, 10'd300, 10'd510, 10'd5};
    alpha_reg = NUM_SYMBOLS_RESET;
    tbl_valid = 1'b0;
    for (int i = 0; i < 1023; i++) node_valid[i] = 1'b0;

    add_row(KIND_FILL, 0, 0, 5, 0);
    add_row(KIND_LOAD, 510, 0, 0, 0);
    add_row(KIND_LOAD, 511, 0, 0, 0);
    add_row(KIND_DECODE, 0, 0, 0, 16'h0000, 1, 5, 0, ERR_OK);
    add_row(KIND_DECODE, 0, 0, 0, 16'hffff, 1, 5, 0, ERR_OK);
    add_row(KIND_FILL, 0, 0, 509, 0);
    add_row(KIND_DECODE, 0, 0, 0, 16'h1234, 1, 509, 0, ERR_OK);
    add_row(KIND_BUILD, 0, 0, 0, 0, 1, 0, 0, ERR_OK);
    add_row(KIND_DECODE, 0, 0, 0, 16'hffff, 1, 0, 0, ERR_OK);
    add_row(KIND_LOAD, 3, 17, 0, 0);
    add_row(KIND_BUILD, 0, 0, 0, 0, 1, 0, 0, ERR_TOO_LONG);
    add_row(KIND_LOAD, 3, 31, 0, 0);
    add_row(KIND_BUILD, 0, 0, 0, 0, 1, 0, 0, ERR_TOO_LONG);
    add_row(KIND_LOAD, 3, 0, 0, 0);
    add_row(KIND_LOAD, 0, 1, 0, 0);
    add_row(KIND_BUILD, 0, 0, 0, 0, 1, 0, 0, ERR_BAD_TOTAL);
    add_row(KIND_LOAD, 1, 1, 0, 0);
    add_row(KIND_BUILD, 0, 0, 0, 0, 1, 0, 0, ERR_OK);
    add_row(KIND_DECODE, 0, 0, 0, 16'h0000, 1, 0, 1, ERR_OK);
    add_row(KIND_DECODE, 0, 0, 0, 16'h8000, 1, 1, 1, ERR_OK);
    // A stored length above the code limit reports the full window.
    add_row(KIND_LOAD, 1, 20, 0, 0);
    add_row(KIND_DECODE, 0, 0, 0, 16'hffff, 1, 1, 16, ERR_OK);
    add_row(KIND_LOAD, 1, 1, 0, 0);
    // Four one-bit codes overrun the table and stop the build.
    add_row(KIND_LOAD, 2, 1, 0, 0);
    add_row(KIND_LOAD, 3, 1, 0, 0);
    add_row(KIND_BUILD, 0, 0, 0, 0, 1, 0, 0, ERR_BAD_ENTRY);
    add_row(KIND_DECODE, 0, 0, 0, 16'hc000);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_item(rows[i].rq, rows[i].typed, rows[i].want);

    foreach (alpha_list[p]) begin
      set_alphabet(alpha_list[p]);
      target = item_cnt + 75;
      while (item_cnt < target) random_round();
    end

    start <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (5000) @(posedge clk_i);
    if (fail_cnt == 0 && exp_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(20 * 5000000);
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
